@@ rtl/event_counter_bank_with_snapshot_macros.svh @@
// Assertion macros for the event counter bank.
// Included by event_counter_bank_with_snapshot; no other dependencies.
// Define NO_ASSERTIONS to compile them out.
`ifndef EVENT_COUNTER_BANK_WITH_SNAPSHOT_MACROS_SVH
`define EVENT_COUNTER_BANK_WITH_SNAPSHOT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, gated by the active-low reset.
`define ECB_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, gated by the active-low reset.
`define ECB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ECB_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define ECB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ rtl/ecb_pkg.sv @@
// Shared types and constants for the event counter bank.
// No dependencies; imported by event_counter_bank_with_snapshot.
`timescale 1ns / 1ps

package ecb_pkg;

    // Bank size (1..30 fits the 6-bit word map)
    localparam int COUNTER_COUNT = 24;
    localparam int CTR_W         = 64;
    localparam int WORD_W        = 32;
    localparam int ADDR_W        = 6;
    localparam int EVENT_W       = 24;
    localparam int CMD_W         = 2;
    localparam int ABI_W         = 16;
    localparam int CFG_IDX_W     = 1;
    localparam int CTR_SEL_W     = ADDR_W - 1;

    typedef logic [CMD_W-1:0]     cmd_t;
    typedef logic [ADDR_W-1:0]    addr_t;
    typedef logic [WORD_W-1:0]    word_t;
    typedef logic [EVENT_W-1:0]   event_t;
    typedef logic [CTR_W-1:0]     ctr_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // Commands
    localparam cmd_t CMD_TICK  = 2'd0;
    localparam cmd_t CMD_READ  = 2'd1;
    localparam cmd_t CMD_WRITE = 2'd2;

    // Word map
    localparam addr_t ADDR_ID       = 6'd0;
    localparam addr_t ADDR_INFO     = 6'd1;
    localparam addr_t ADDR_CONTROL  = 6'd2;
    localparam addr_t ADDR_STATUS   = 6'd3;
    localparam addr_t ADDR_COUNTERS = 6'd4;

    // CONTROL bit positions
    localparam int CTL_ENABLE   = 0;
    localparam int CTL_CLEAR    = 1;
    localparam int CTL_SNAPSHOT = 2;
    localparam int CTL_RELEASE  = 3;

    // STATUS bit positions
    localparam int STS_ENABLED = 0;
    localparam int STS_HELD    = 1;

    // Configuration register indexes
    localparam cfg_idx_t CFG_ID_VALUE    = 1'd0;
    localparam cfg_idx_t CFG_ABI_VERSION = 1'd1;

    localparam word_t ID_RESET          = '0;
    localparam logic [ABI_W-1:0] ABI_RESET = 16'd1;

    // Counter count as reported in INFO[7:0]
    localparam logic [7:0] INFO_COUNT = 8'(COUNTER_COUNT & 8'hFF);

    // One accepted input transfer
    typedef struct packed {
        cmd_t   cmd;
        addr_t  word_address;
        word_t  write_value;
        event_t event_flags;
    } ecb_item_t;

endpackage

@@ rtl/event_counter_bank_with_snapshot.sv @@
// Event counter bank with snapshot shadow, two-register pipeline.
// Depends on ecb_pkg and event_counter_bank_with_snapshot_macros.svh.
`timescale 1ns / 1ps
//
//  Channel   Direction  Handshake             Payload
//  --------  ---------  --------------------  -----------------------------------------
//  s_        in         s_valid / s_ready     s_cmd, s_word_address, s_write_value,
//                                             s_event_flags
//  m_        out        m_valid / m_ready     m_read_value
//  cfg_      in         cfg_valid / cfg_ready cfg_index, cfg_data (always ready)
//
//  One item per cycle sustained while m_ready stays high. An accepted item is held
//  in the input register, then executes (counter update, control write or register
//  read) as it moves into the result register, which drives m_valid.
//  The execute step is 24 parallel 64-bit incrementers plus a 48-word read mux.
//  Reset (aresetn low, synchronous) zeroes both counter banks, clears enable
//  and hold, and restores id_value = 0, abi_version = 1.
//  An m_ stall holds the result register; the input register still fills, so
//  s_ready drops only when both registers are full and m_ready is low.

`include "event_counter_bank_with_snapshot_macros.svh"

module event_counter_bank_with_snapshot
    import ecb_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  cmd_t                 s_cmd,
    input  addr_t                s_word_address,
    input  word_t                s_write_value,
    input  event_t               s_event_flags,

    output logic                 m_valid,
    input  logic                 m_ready,
    output word_t                m_read_value,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  cfg_idx_t             cfg_index,
    input  word_t                cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    word_t            id_value_reg;
    logic [ABI_W-1:0] abi_version_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            id_value_reg    <= ID_RESET;
            abi_version_reg <= ABI_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_ID_VALUE:    id_value_reg    <= cfg_data;
                CFG_ABI_VERSION: abi_version_reg <= cfg_data[ABI_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control
    //   s1: input register, m: result register.
    //   advance moves the s1 item through execute into the result register.
    // ------------------------------------------------------------------
    logic      s1_valid_reg;
    ecb_item_t s1_item_reg;
    logic      m_valid_reg;
    word_t     m_read_value_reg;
    logic      advance;
    logic      s_xfer;

    assign advance = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !s1_valid_reg || advance;
    assign s_xfer  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            s1_item_reg <= '{cmd:          s_cmd,
                             word_address: s_word_address,
                             write_value:  s_write_value,
                             event_flags:  s_event_flags};
        end
    end

    // ------------------------------------------------------------------
    // Counter state
    // ------------------------------------------------------------------
    ctr_t live_counts_reg   [COUNTER_COUNT];
    ctr_t frozen_counts_reg [COUNTER_COUNT];
    logic counting_on_reg;
    logic freeze_held_reg;

    // Decode of the item being executed
    logic is_tick;
    logic is_read;
    logic ctl_write;
    logic do_snapshot;
    logic do_release;
    logic do_clear;

    assign is_tick     = advance && (s1_item_reg.cmd == CMD_TICK) && counting_on_reg;
    assign is_read     = (s1_item_reg.cmd == CMD_READ);
    assign ctl_write   = advance && (s1_item_reg.cmd == CMD_WRITE)
                         && (s1_item_reg.word_address == ADDR_CONTROL);
    assign do_snapshot = ctl_write && s1_item_reg.write_value[CTL_SNAPSHOT];
    assign do_release  = ctl_write && s1_item_reg.write_value[CTL_RELEASE];
    assign do_clear    = ctl_write && s1_item_reg.write_value[CTL_CLEAR];

    // Event bits per counter; counters past the flag field never see events
    logic [COUNTER_COUNT-1:0] ctr_hit;

    for (genvar g = 0; g < COUNTER_COUNT; g++) begin : g_hit
        if (g < EVENT_W) begin : g_flag
            assign ctr_hit[g] = s1_item_reg.event_flags[g];
        end else begin : g_none
            assign ctr_hit[g] = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < COUNTER_COUNT; i++) begin
                live_counts_reg[i] <= '0;
            end
        end else begin
            for (int i = 0; i < COUNTER_COUNT; i++) begin
                if (do_clear) begin
                    live_counts_reg[i] <= '0;
                end else if (is_tick && ctr_hit[i]) begin
                    live_counts_reg[i] <= live_counts_reg[i] + CTR_W'(1);
                end
            end
        end
    end

    // Snapshot copies pre-clear live values
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < COUNTER_COUNT; i++) begin
                frozen_counts_reg[i] <= '0;
            end
        end else if (do_snapshot) begin
            for (int i = 0; i < COUNTER_COUNT; i++) begin
                frozen_counts_reg[i] <= live_counts_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            counting_on_reg <= 1'b0;
            freeze_held_reg <= 1'b0;
        end else if (ctl_write) begin
            counting_on_reg <= s1_item_reg.write_value[CTL_ENABLE];
            // snapshot wins over release
            if (do_snapshot) begin
                freeze_held_reg <= 1'b1;
            end else if (do_release) begin
                freeze_held_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Register read mux
    //   counter word 4+2i is the low half of counter i, 5+2i the high half.
    // ------------------------------------------------------------------
    logic [CTR_SEL_W-1:0] ctr_sel;
    logic                 ctr_in_range;
    ctr_t                 ctr_value;
    word_t                read_word;
    word_t                read_value_next;

    assign ctr_sel = s1_item_reg.word_address[ADDR_W-1:1]
                     - ADDR_COUNTERS[ADDR_W-1:1];

    always_comb begin
        ctr_in_range = 1'b0;
        ctr_value    = '0;
        for (int i = 0; i < COUNTER_COUNT; i++) begin
            if (ctr_sel == CTR_SEL_W'(i)) begin
                ctr_in_range = 1'b1;
                ctr_value    = freeze_held_reg ? frozen_counts_reg[i] : live_counts_reg[i];
            end
        end
    end

    always_comb begin
        read_word = '0;
        case (s1_item_reg.word_address)
            ADDR_ID:      read_word = id_value_reg;
            ADDR_INFO:    read_word = {abi_version_reg, 8'h00, INFO_COUNT};
            ADDR_CONTROL: read_word[STS_ENABLED] = counting_on_reg;
            ADDR_STATUS: begin
                read_word[STS_ENABLED] = counting_on_reg;
                read_word[STS_HELD]    = freeze_held_reg;
            end
            default: begin
                if (ctr_in_range) begin
                    read_word = s1_item_reg.word_address[0] ? ctr_value[CTR_W-1:WORD_W]
                                                            : ctr_value[WORD_W-1:0];
                end
            end
        endcase
        read_value_next = is_read ? read_word : '0;
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_read_value_reg <= read_value_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_read_value = m_read_value_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ECB_ASSERT_NEXT(a_exec_gives_result, aclk, aresetn, advance, m_valid_reg,
                     "executed item did not reach the result register")
    `ECB_ASSERT_NEXT(a_nonread_zero, aclk, aresetn, advance && !is_read,
                     m_read_value_reg == '0, "non-read transfer returned nonzero data")
    `ECB_ASSERT_NEXT(a_snapshot_holds, aclk, aresetn, do_snapshot,
                     freeze_held_reg, "snapshot did not set the hold")
    `ECB_ASSERT_NEXT(a_clear_zeroes, aclk, aresetn, do_clear && !do_snapshot,
                     live_counts_reg[0] == '0, "clear left a live counter nonzero")
    `ECB_ASSERT_SAME(a_full_stall, aclk, aresetn, s1_valid_reg && m_valid_reg && !m_ready,
                     !s_ready, "input accepted while both stages are full")

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// Testbench for event_counter_bank_with_snapshot: directed and random register traffic,
// each read word checked against an in-bench model of the counter bank.
// Depends on ecb_pkg and the block's RTL only.

module testbench;
    import ecb_pkg::*;

    localparam cmd_t  CMD_UNUSED     = 2'd3;
    localparam addr_t LAST_CTR_HI    = addr_t'(ADDR_COUNTERS + 2 * COUNTER_COUNT - 1);
    localparam addr_t FIRST_UNMAPPED = addr_t'(ADDR_COUNTERS + 2 * COUNTER_COUNT);
    localparam int    MAX_PRINTS     = 40;

    typedef struct packed {
        ecb_item_t item;
        word_t     rd;
    } expected_read_t;

    logic     aclk           = 1'b0;
    logic     aresetn        = 1'b0;
    logic     s_valid        = 1'b0;
    logic     s_ready;
    cmd_t     s_cmd          = CMD_TICK;
    addr_t    s_word_address = '0;
    word_t    s_write_value  = '0;
    event_t   s_event_flags  = '0;
    logic     m_valid;
    logic     m_ready        = 1'b0;
    word_t    m_read_value;
    logic     cfg_valid      = 1'b0;
    logic     cfg_ready;
    cfg_idx_t cfg_index      = CFG_ID_VALUE;
    word_t    cfg_data       = '0;

    // Bank model: live and shadow counters, enable/hold flags, config registers
    ctr_t             live_ctr [COUNTER_COUNT];
    ctr_t             shadow_ctr [COUNTER_COUNT];
    logic             count_en;
    logic             shadow_held;
    word_t            id_reg;
    logic [ABI_W-1:0] abi_reg;

    expected_read_t read_data_q[$];
    int             mismatch_count = 0;
    int             send_idle_pct  = 0;
    int             recv_stall_pct = 0;

    // Long receiver hold-off: test code bumps hold_req, receiver process counts it out
    int hold_req  = 0;
    int hold_len  = 0;
    int hold_ack  = 0;
    int hold_left = 0;

    event_counter_bank_with_snapshot u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_word_address (s_word_address),
        .s_write_value  (s_write_value),
        .s_event_flags  (s_event_flags),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_read_value   (m_read_value),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Applies one item to the bank model and returns the word it reads back
    function automatic word_t bank_step(ecb_item_t it);
        word_t rd;
        int    sel;
        ctr_t  v;
        rd = '0;
        case (it.cmd)
            CMD_TICK: begin
                if (count_en) begin
                    for (int i = 0; i < COUNTER_COUNT && i < EVENT_W; i++) begin
                        if (it.event_flags[i])
                            live_ctr[i] = live_ctr[i] + 1'b1;
                    end
                end
            end
            CMD_READ: begin
                if (it.word_address == ADDR_ID) begin
                    rd = id_reg;
                end else if (it.word_address == ADDR_INFO) begin
                    rd = {abi_reg, 8'h00, 8'(COUNTER_COUNT)};
                end else if (it.word_address == ADDR_CONTROL) begin
                    rd[CTL_ENABLE] = count_en;
                end else if (it.word_address == ADDR_STATUS) begin
                    rd[STS_ENABLED] = count_en;
                    rd[STS_HELD]    = shadow_held;
                end else begin
                    sel = (int'(it.word_address) - int'(ADDR_COUNTERS)) >> 1;
                    if (sel < COUNTER_COUNT) begin
                        v  = shadow_held ? shadow_ctr[sel] : live_ctr[sel];
                        rd = it.word_address[0] ? v[CTR_W-1:WORD_W] : v[WORD_W-1:0];
                    end
                end
            end
            CMD_WRITE: begin
                // only CONTROL takes writes; snapshot beats release, copy precedes clear
                if (it.word_address == ADDR_CONTROL) begin
                    if (it.write_value[CTL_SNAPSHOT]) begin
                        for (int i = 0; i < COUNTER_COUNT; i++)
                            shadow_ctr[i] = live_ctr[i];
                        shadow_held = 1'b1;
                    end else if (it.write_value[CTL_RELEASE]) begin
                        shadow_held = 1'b0;
                    end
                    if (it.write_value[CTL_CLEAR]) begin
                        for (int i = 0; i < COUNTER_COUNT; i++)
                            live_ctr[i] = '0;
                    end
                    count_en = it.write_value[CTL_ENABLE];
                end
            end
            default: ;
        endcase
        return rd;
    endfunction

    task automatic report_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
            $display("%0t ns MISMATCH %s", $time, what);
    endtask

    // Result checker
    always @(posedge aclk) begin : check_results
        expected_read_t e;
        if (aresetn && m_valid && m_ready) begin
            if (read_data_q.size() == 0) begin
                report_mismatch($sformatf("read_value 0x%08h with nothing outstanding",
                                          m_read_value));
            end else begin
                e = read_data_q.pop_front();
                if (m_read_value !== e.rd)
                    report_mismatch($sformatf("cmd %0d addr %0d: read_value 0x%08h, want 0x%08h",
                                              e.item.cmd, e.item.word_address,
                                              m_read_value, e.rd));
            end
        end
    end

    // Receiver: random stalls, plus a counted hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req != hold_ack) begin
            m_ready   <= 1'b0;
            hold_ack  <= hold_req;
            hold_left <= hold_len;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic word_t ctl_word(logic en, logic clr, logic snap, logic rel);
        word_t w;
        w               = '0;
        w[CTL_ENABLE]   = en;
        w[CTL_CLEAR]    = clr;
        w[CTL_SNAPSHOT] = snap;
        w[CTL_RELEASE]  = rel;
        return w;
    endfunction

    function automatic addr_t ctr_lo(int i);
        return addr_t'(ADDR_COUNTERS + 2 * i);
    endfunction

    // One transfer on s_; valid stays up across back-to-back transfers
    task automatic send_item(cmd_t cmd, addr_t addr, word_t wval, event_t flags);
        ecb_item_t      it;
        expected_read_t e;
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid        <= 1'b1;
        s_cmd          <= cmd;
        s_word_address <= addr;
        s_write_value  <= wval;
        s_event_flags  <= flags;
        do @(posedge aclk); while (!s_ready);
        it.cmd          = cmd;
        it.word_address = addr;
        it.write_value  = wval;
        it.event_flags  = flags;
        e.item = it;
        e.rd   = bank_step(it);
        read_data_q.push_back(e);
    endtask

    // Stop sending and wait for every outstanding read word
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (read_data_q.size() != 0);
    endtask

    // Only called with the bank idle
    task automatic write_config(cfg_idx_t idx, word_t data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_ID_VALUE)
            id_reg = data;
        else
            abi_reg = data[ABI_W-1:0];
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic addr_t random_addr();
        case ($urandom_range(9))
            0, 1:    return addr_t'($urandom_range(ADDR_STATUS));
            2:       return addr_t'($urandom);
            default: return addr_t'(ADDR_COUNTERS + $urandom_range(2 * COUNTER_COUNT - 1));
        endcase
    endfunction

    function automatic event_t random_flags();
        case ($urandom_range(5))
            0:       return '1;
            1:       return event_t'(1) << $urandom_range(EVENT_W - 1);
            2:       return '0;
            default: return event_t'($urandom);
        endcase
    endfunction

    // Mostly enabled; clear kept rare so counts build up
    function automatic word_t random_ctl();
        word_t w;
        w               = $urandom;
        w[CTL_ENABLE]   = ($urandom_range(9) != 0);
        w[CTL_CLEAR]    = ($urandom_range(5) == 0);
        w[CTL_SNAPSHOT] = ($urandom_range(3) == 0);
        w[CTL_RELEASE]  = ($urandom_range(2) == 0);
        return w;
    endfunction

    task automatic send_random_item();
        int pick;
        pick = $urandom_range(99);
        if (pick < 52)
            send_item(CMD_TICK, random_addr(), $urandom, random_flags());
        else if (pick < 82)
            send_item(CMD_READ, random_addr(), $urandom, random_flags());
        else if (pick < 95 && $urandom_range(3) != 0)
            send_item(CMD_WRITE, ADDR_CONTROL, random_ctl(), random_flags());
        else if (pick < 95)
            send_item(CMD_WRITE, random_addr(), $urandom, random_flags());
        else
            send_item(CMD_UNUSED, random_addr(), $urandom, random_flags());
    endtask

    task automatic test_reset_state();
        send_item(CMD_READ, ADDR_ID, '0, '0);
        send_item(CMD_READ, ADDR_INFO, '0, '0);
        send_item(CMD_READ, ADDR_STATUS, '0, '0);
        send_item(CMD_READ, ctr_lo(0) + 1'b1, '0, '0);
        send_item(CMD_READ, LAST_CTR_HI, '0, '0);
        send_item(CMD_READ, FIRST_UNMAPPED, '0, '0);
        drain();
    endtask

    task automatic test_config_regs();
        write_config(CFG_ID_VALUE, '1);
        write_config(CFG_ABI_VERSION, word_t'({ABI_W{1'b1}}));
        send_item(CMD_READ, ADDR_ID, '0, '0);
        send_item(CMD_READ, ADDR_INFO, '0, '0);
        drain();
    endtask

    task automatic test_control_ops();
        send_item(CMD_WRITE, ADDR_CONTROL, ctl_word(1'b1, 1'b0, 1'b0, 1'b0), '0);
        send_item(CMD_TICK, ADDR_ID, '0, '1);
        send_item(CMD_TICK, ADDR_ID, '0, event_t'(1) << (EVENT_W - 1));
        // snapshot together with release: hold stays set
        send_item(CMD_WRITE, ADDR_CONTROL, ctl_word(1'b1, 1'b0, 1'b1, 1'b1), '0);
        send_item(CMD_TICK, ADDR_ID, '0, '1);
        send_item(CMD_READ, ctr_lo(0), '0, '0);
        send_item(CMD_READ, ADDR_STATUS, '0, '0);
        send_item(CMD_WRITE, ADDR_CONTROL, ctl_word(1'b1, 1'b0, 1'b0, 1'b1), '0);
        send_item(CMD_READ, ctr_lo(COUNTER_COUNT - 1), '0, '0);
        // snapshot with clear: shadow keeps the pre-clear counts
        send_item(CMD_WRITE, ADDR_CONTROL, ctl_word(1'b1, 1'b1, 1'b1, 1'b0), '0);
        send_item(CMD_READ, ctr_lo(COUNTER_COUNT - 1), '0, '0);
        // release and disable, then a tick that must not count
        send_item(CMD_WRITE, ADDR_CONTROL, ctl_word(1'b0, 1'b0, 1'b0, 1'b1), '0);
        send_item(CMD_TICK, ADDR_ID, '0, '1);
        send_item(CMD_READ, ctr_lo(COUNTER_COUNT - 1), '0, '0);
        send_item(CMD_WRITE, ADDR_ID, '1, '1);
        send_item(CMD_UNUSED, ADDR_CONTROL, '1, '1);
        send_item(CMD_READ, ADDR_CONTROL, '1, '1);
        drain();
    endtask

    task automatic run_phase(int idle_pct, int stall_pct, int n);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (n) send_random_item();
        drain();
    endtask

    task automatic test_random_traffic();
        run_phase(15, 79, 250);
        write_config(CFG_ID_VALUE, '0);
        write_config(CFG_ABI_VERSION, '0);
        run_phase(79, 15, 250);
        write_config(CFG_ID_VALUE, $urandom);
        write_config(CFG_ABI_VERSION, word_t'($urandom_range(16'hFFFF)));
        run_phase(0, 0, 250);
    endtask

    // Receiver holds off while the sender keeps offering, so s_ready must drop
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_len       = 60;
        hold_req       = hold_req + 1;
        repeat (40) send_random_item();
        drain();
    endtask

    initial begin
        for (int i = 0; i < COUNTER_COUNT; i++) begin
            live_ctr[i]   = '0;
            shadow_ctr[i] = '0;
        end
        count_en    = 1'b0;
        shadow_held = 1'b0;
        id_reg      = ID_RESET;
        abi_reg     = ABI_RESET;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_state();
        test_config_regs();
        test_control_ops();
        test_random_traffic();
        test_backpressure();

        // two-stage pipe; spare clocks at the end catch stray transfers
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/ecb_pkg.sv
rtl/event_counter_bank_with_snapshot.sv
sim/testbench.sv
